FILE: rtl/bc_pkg.sv
package bc_pkg;

	// Calibration word, raw conversion and result widths
	localparam int CAL_W   = 16;
	localparam int RAW_W   = 24;
	localparam int PRESS_W = 32;
	localparam int TEMP_W  = 19;

	// APB data and address widths (six 16-bit registers in 32-bit words at 4*i)
	localparam int APB_DW = 32;
	localparam int APB_AW = 5;

	// Internal datapath widths
	localparam int DT_W    = 25;  // ut - c5*256
	localparam int TCP_W   = 41;  // 16x25 temperature coefficient products
	localparam int DTEMP_W = 18;  // temperature - 2000
	localparam int ACC_W   = 41;  // OFF, SENS and their corrections
	localparam int DD_W    = 36;  // (temperature - 2000)^2
	localparam int EE_W    = 38;  // (temperature + 1500)^2
	localparam int PLO_W   = 20;  // low slice of SENS for the final multiply
	localparam int PPL_W   = RAW_W + PLO_W;
	localparam int PPH_W   = RAW_W + 1 + ACC_W - PLO_W;
	localparam int PROD_W  = PPH_W + PLO_W;

	// Scheme constants
	localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
	localparam logic signed [TEMP_W-1:0] TEMP_COLD = 19'sd1500;

	// Register map
	typedef enum logic [2:0] {
		REG_SENS_BASE   = 3'd0,
		REG_OFF_BASE    = 3'd1,
		REG_SENS_TEMPCO = 3'd2,
		REG_OFF_TEMPCO  = 3'd3,
		REG_REF_TEMP    = 3'd4,
		REG_TEMP_SLOPE  = 3'd5
	} reg_idx_t;

endpackage

FILE: rtl/barometer_compensation.sv
// Pressure and temperature compensation pipeline for a 24-bit barometer.
// Throughput: one word per cycle while out_ready holds; each stage holds at most one word and a
// stall only backs up the stages behind a full one.
// Reset: arst_n clears all valid bits and the six calibration registers.
module barometer_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bc_pkg::APB_AW-1:0]     paddr,
	input  logic [bc_pkg::APB_DW-1:0]     pwdata,
	output logic [bc_pkg::APB_DW-1:0]     prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bc_pkg::RAW_W-1:0]      raw_pressure,
	input  logic [bc_pkg::RAW_W-1:0]      raw_temperature,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [bc_pkg::PRESS_W-1:0] pressure,
	output logic signed [bc_pkg::TEMP_W-1:0]  temperature
);
	import bc_pkg::*;

	// Calibration registers
	logic [CAL_W-1:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
	reg_idx_t         reg_idx;
	logic             cfg_wr;

	// Stage valid bits and advance enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv8, adv9;

	// Stage payloads
	logic [RAW_W-1:0]          up_s1, up_s2, up_s3, up_s4, up_s5, up_s6;
	logic signed [DT_W-1:0]    dt_s1;
	logic signed [TCP_W-1:0]   poff_s2, psens_s2, ptemp_s2;
	logic signed [ACC_W-1:0]   off_s3, off_s4, off_s5, off_s6, off_s7, off_s8;
	logic signed [ACC_W-1:0]   sens_s3, sens_s4, sens_s5, sens_s6;
	logic signed [DTEMP_W-1:0] d_s3;
	logic signed [TEMP_W-1:0]  f_s3;
	logic signed [TEMP_W-1:0]  temp_s3, temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;
	logic signed [TEMP_W-1:0]  temp_s9;
	logic                      cold_s3, cold_s4, vcold_s3, vcold_s4;
	logic signed [DD_W-1:0]    dd_s4;
	logic signed [EE_W-1:0]    ee_s4;
	logic signed [ACC_W-1:0]   coff_s5, csens_s5;
	logic [PPL_W-1:0]          pplo_s7;
	logic signed [PPH_W-1:0]   pphi_s7;
	logic signed [PROD_W-1:0]  prod_s8;
	logic signed [PRESS_W-1:0] press_s9;

	// Combinational helpers
	logic signed [ACC_W-1:0]   offtc_c, senstc_c;
	logic signed [DTEMP_W-1:0] dtemp_c;
	logic signed [TEMP_W-1:0]  temp_c, f_c;
	logic signed [ACC_W-1:0]   dd_x, ee_x, q_c, e7_c, e11_c;
	logic signed [ACC_W-1:0]   coff_c, csens_c;
	logic signed [PROD_W-1:0]  diff_c;

	localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;

	// APB register port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SENS_BASE:   c1_q <= pwdata[CAL_W-1:0];
				REG_OFF_BASE:    c2_q <= pwdata[CAL_W-1:0];
				REG_SENS_TEMPCO: c3_q <= pwdata[CAL_W-1:0];
				REG_OFF_TEMPCO:  c4_q <= pwdata[CAL_W-1:0];
				REG_REF_TEMP:    c5_q <= pwdata[CAL_W-1:0];
				REG_TEMP_SLOPE:  c6_q <= pwdata[CAL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (reg_idx)
			REG_SENS_BASE:   prdata = {{(APB_DW-CAL_W){1'b0}}, c1_q};
			REG_OFF_BASE:    prdata = {{(APB_DW-CAL_W){1'b0}}, c2_q};
			REG_SENS_TEMPCO: prdata = {{(APB_DW-CAL_W){1'b0}}, c3_q};
			REG_OFF_TEMPCO:  prdata = {{(APB_DW-CAL_W){1'b0}}, c4_q};
			REG_REF_TEMP:    prdata = {{(APB_DW-CAL_W){1'b0}}, c5_q};
			REG_TEMP_SLOPE:  prdata = {{(APB_DW-CAL_W){1'b0}}, c6_q};
			default:         prdata = '0;
		endcase
	end

	// Advance a stage when it is empty or its word moves on
	assign adv9 = !vld_s9 || out_ready;
	assign adv8 = !vld_s8 || adv9;
	assign adv7 = !vld_s7 || adv8;
	assign adv6 = !vld_s6 || adv7;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	assign in_ready  = adv1;
	assign out_valid = vld_s9;
	assign pressure    = press_s9;
	assign temperature = temp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
			if (adv7) vld_s7 <= vld_s6;
			if (adv8) vld_s8 <= vld_s7;
			if (adv9) vld_s9 <= vld_s8;
		end
	end

	// Stage 1: temperature difference dT
	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			up_s1 <= raw_pressure;
			dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, c5_q, 8'd0});
		end
	end

	// Stage 2: coefficient products of dT
	always_ff @(posedge clk) begin
		if (adv2 && vld_s1) begin
			up_s2    <= up_s1;
			poff_s2  <= TCP_W'($signed({1'b0, c4_q})) * TCP_W'(dt_s1);
			psens_s2 <= TCP_W'($signed({1'b0, c3_q})) * TCP_W'(dt_s1);
			ptemp_s2 <= TCP_W'($signed({1'b0, c6_q})) * TCP_W'(dt_s1);
		end
	end

	// Stage 3: first-order OFF, SENS and temperature
	assign offtc_c  = poff_s2 >>> 7;
	assign senstc_c = psens_s2 >>> 8;
	assign dtemp_c  = $signed(ptemp_s2[TCP_W-1:TCP_W-DTEMP_W]);
	assign temp_c   = $signed({dtemp_c[DTEMP_W-1], dtemp_c}) + TEMP_REF;
	assign f_c      = temp_c + TEMP_COLD;

	always_ff @(posedge clk) begin
		if (adv3 && vld_s2) begin
			up_s3    <= up_s2;
			off_s3   <= $signed({{(ACC_W-CAL_W-16){1'b0}}, c2_q, 16'd0}) + offtc_c;
			sens_s3  <= $signed({{(ACC_W-CAL_W-15){1'b0}}, c1_q, 15'd0}) + senstc_c;
			d_s3     <= dtemp_c;
			f_s3     <= f_c;
			temp_s3  <= temp_c;
			cold_s3  <= dtemp_c[DTEMP_W-1];
			vcold_s3 <= f_c[TEMP_W-1];
		end
	end

	// Stage 4: squares for the low-temperature corrections
	always_ff @(posedge clk) begin
		if (adv4 && vld_s3) begin
			up_s4    <= up_s3;
			off_s4   <= off_s3;
			sens_s4  <= sens_s3;
			temp_s4  <= temp_s3;
			cold_s4  <= cold_s3;
			vcold_s4 <= vcold_s3;
			dd_s4    <= DD_W'(d_s3) * DD_W'(d_s3);
			ee_s4    <= EE_W'(f_s3) * EE_W'(f_s3);
		end
	end

	// Stage 5: correction terms by shift and add
	assign dd_x  = $signed({{(ACC_W-DD_W){dd_s4[DD_W-1]}}, dd_s4});
	assign ee_x  = $signed({{(ACC_W-EE_W){ee_s4[EE_W-1]}}, ee_s4});
	assign q_c   = (dd_x <<< 2) + dd_x;
	assign e7_c  = (ee_x <<< 3) - ee_x;
	assign e11_c = (ee_x <<< 3) + (ee_x <<< 1) + ee_x;

	always_comb begin
		coff_c  = ACC_ZERO;
		csens_c = ACC_ZERO;
		if (cold_s4) begin
			coff_c  = q_c >>> 1;
			csens_c = q_c >>> 2;
		end
		if (vcold_s4) begin
			coff_c  = coff_c + e7_c;
			csens_c = csens_c + (e11_c >>> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv5 && vld_s4) begin
			up_s5    <= up_s4;
			off_s5   <= off_s4;
			sens_s5  <= sens_s4;
			temp_s5  <= temp_s4;
			coff_s5  <= coff_c;
			csens_s5 <= csens_c;
		end
	end

	// Stage 6: apply corrections
	always_ff @(posedge clk) begin
		if (adv6 && vld_s5) begin
			up_s6   <= up_s5;
			temp_s6 <= temp_s5;
			off_s6  <= off_s5 - coff_s5;
			sens_s6 <= sens_s5 - csens_s5;
		end
	end

	// Stage 7: raw pressure times SENS as two partial products
	always_ff @(posedge clk) begin
		if (adv7 && vld_s6) begin
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
			pplo_s7 <= PPL_W'(up_s6) * PPL_W'(sens_s6[PLO_W-1:0]);
			pphi_s7 <= PPH_W'($signed({1'b0, up_s6}))
				* PPH_W'($signed(sens_s6[ACC_W-1:PLO_W]));
		end
	end

	// Stage 8: combine partial products
	always_ff @(posedge clk) begin
		if (adv8 && vld_s7) begin
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
			prod_s8 <= $signed({pphi_s7, {PLO_W{1'b0}}})
				+ $signed({{(PROD_W-PPL_W){1'b0}}, pplo_s7});
		end
	end

	// Stage 9: scale, subtract OFF, scale again, keep low 32 bits
	assign diff_c = (prod_s8 >>> 21)
		- $signed({{(PROD_W-ACC_W){off_s8[ACC_W-1]}}, off_s8});

	always_ff @(posedge clk) begin
		if (adv9 && vld_s8) begin
			temp_s9  <= temp_s8;
			press_s9 <= $signed(diff_c[PRESS_W+15-1:15]);
		end
	end

`ifndef SYNTHESIS
	// Below -15 degC always implies below 20 degC
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && vcold_s3) |-> cold_s3)
		else $error("cold flags inconsistent");

	// Correction terms never add to OFF or SENS
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 |-> (!coff_s5[ACC_W-1] && !csens_s5[ACC_W-1]))
		else $error("negative correction term");

	// A square is never negative
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (!dd_s4[DD_W-1] && !ee_s4[EE_W-1]))
		else $error("negative square");

	// An accepted word lands in stage one
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_s1)
		else $error("input word lost");

	// A blocked stage 8 keeps its word
	assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s8 && !adv8) |=> (vld_s8 && $stable(prod_s8)))
		else $error("stalled word dropped");
`endif

endmodule

FILE: test/barometer_compensation_tb.sv
module barometer_compensation_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bc_pkg::*;

	localparam int NUM_REGS        = 6;
	localparam int LATENCY         = 9;
	localparam int IDLE_PCT        = 32;
	localparam int LONG_HOLD       = 80;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int MAX_REPORTS     = 30;

	localparam longint WARM_LIMIT = TEMP_REF;
	localparam longint COLD_LIMIT = -longint'(TEMP_COLD);
	localparam logic [RAW_W-1:0] RAW_MAX = '1;
	localparam logic [CAL_W-1:0] CAL_MAX = '1;

	// Calibration words of a typical part
	localparam logic [CAL_W-1:0] NOMINAL_CAL [NUM_REGS] = '{
		16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312
	};

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		logic signed [PRESS_W-1:0] pressure;
		logic signed [TEMP_W-1:0]  temperature;
	} baro_reading_t;

	typedef struct {
		row_kind_t          kind;
		int                 reg_index;
		logic [APB_DW-1:0]  reg_value;
		logic [RAW_W-1:0]   up;
		logic [RAW_W-1:0]   ut;
		bit                 typed;
		baro_reading_t      reading;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;

	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	logic              in_valid        = 1'b0;
	logic              in_ready;
	logic [RAW_W-1:0]  raw_pressure    = '0;
	logic [RAW_W-1:0]  raw_temperature = '0;
	logic              out_valid;
	logic              out_ready       = 1'b0;
	logic signed [PRESS_W-1:0] pressure;
	logic signed [TEMP_W-1:0]  temperature;

	// Shadow of the calibration registers
	logic [CAL_W-1:0] cal_word [NUM_REGS] = '{default: '0};

	baro_reading_t expected_readings [$];
	baro_reading_t oldest;
	stim_row_t     stim_rows [$];

	int  errors        = 0;
	int  items_sent    = 0;
	int  results_seen  = 0;
	int  cold_items    = 0;
	int  frigid_items  = 0;
	int  cal_settings  = 0;
	int  quiet_cycles  = 0;
	bit  no_idle       = 1'b0;
	bit  hold_request  = 1'b0;

	barometer_compensation DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.pressure        (pressure),
		.temperature     (temperature)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Compensate one raw pair with the shadow calibration
	function automatic baro_reading_t compensate_reading(input logic [RAW_W-1:0] up_raw,
			input logic [RAW_W-1:0] ut_raw);
		longint up, dt, off, sens, temp, sq, press;
		baro_reading_t r;
		up   = longint'(up_raw);
		dt   = longint'(ut_raw) - longint'(cal_word[REG_REF_TEMP]) * 256;
		off  = longint'(cal_word[REG_OFF_BASE]) * 65536
			+ ((longint'(cal_word[REG_OFF_TEMPCO]) * dt) >>> 7);
		sens = longint'(cal_word[REG_SENS_BASE]) * 32768
			+ ((longint'(cal_word[REG_SENS_TEMPCO]) * dt) >>> 8);
		temp = WARM_LIMIT + ((dt * longint'(cal_word[REG_TEMP_SLOPE])) >>> 23);
		// second-order terms below 20 degC, more below -15 degC
		if (temp < WARM_LIMIT) begin
			sq = 5 * (temp - WARM_LIMIT) * (temp - WARM_LIMIT);
			off  -= sq >>> 1;
			sens -= sq >>> 2;
			if (temp < COLD_LIMIT) begin
				sq = (temp - COLD_LIMIT) * (temp - COLD_LIMIT);
				off  -= 7 * sq;
				sens -= (11 * sq) >>> 1;
			end
		end
		press = (((up * sens) >>> 21) - off) >>> 15;
		r.pressure    = press[PRESS_W-1:0];
		r.temperature = temp[TEMP_W-1:0];
		return r;
	endfunction

	function automatic void add_item(input logic [RAW_W-1:0] up, input logic [RAW_W-1:0] ut,
			input bit typed, input baro_reading_t reading);
		stim_row_t row;
		row.kind      = ROW_ITEM;
		row.reg_index = 0;
		row.reg_value = '0;
		row.up        = up;
		row.ut        = ut;
		row.typed     = typed;
		row.reading   = reading;
		stim_rows.push_back(row);
	endfunction

	function automatic void add_cfg(input int idx, input logic [APB_DW-1:0] value);
		stim_row_t row;
		row.kind      = ROW_CFG;
		row.reg_index = idx;
		row.reg_value = value;
		row.up        = '0;
		row.ut        = '0;
		row.typed     = 1'b0;
		row.reading   = '{pressure: 0, temperature: 0};
		stim_rows.push_back(row);
	endfunction

	// One APB transfer; a read is checked against the shadow
	task automatic apb_access(input bit is_write, input int idx, input logic [APB_DW-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= APB_AW'(idx * 4);
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (is_write) begin
			if (idx < NUM_REGS)
				cal_word[idx] = value[CAL_W-1:0];
		end else if (prdata !== APB_DW'(cal_word[idx])) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: register %0d readback expected %h actual %h",
					$time, idx, APB_DW'(cal_word[idx]), prdata);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic verify_regs();
		for (int i = 0; i < NUM_REGS; i++)
			apb_access(1'b0, i, '0);
	endtask

	// Offer one input word, hold it until accepted, then log its expectation
	task automatic send_item(input logic [RAW_W-1:0] up, input logic [RAW_W-1:0] ut,
			input bit typed, input baro_reading_t reading);
		baro_reading_t want;
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid        <= 1'b1;
		raw_pressure    <= up;
		raw_temperature <= ut;
		do @(posedge clk); while (!in_ready);
		want = compensate_reading(up, ut);
		if (want.temperature < WARM_LIMIT)
			cold_items++;
		if (want.temperature < COLD_LIMIT)
			frigid_items++;
		if (typed)
			want = reading;
		expected_readings.push_back(want);
		items_sent++;
	endtask

	// Drop valid and wait until the pipeline has emptied
	task automatic settle_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	// Drive out_ready: random idling, no-idle stretches and a long hold-off
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Check each result word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_readings.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result word, actual pressure %0d temperature %0d",
						$time, pressure, temperature);
			end else begin
				oldest = expected_readings.pop_front();
				if (pressure !== oldest.pressure) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: pressure expected %0d actual %0d",
							$time, oldest.pressure, pressure);
				end
				if (temperature !== oldest.temperature) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: temperature expected %0d actual %0d",
							$time, oldest.temperature, temperature);
				end
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles, %0d results outstanding",
				$time, WATCHDOG_LIMIT, expected_readings.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin : stimulus
		logic [RAW_W-1:0] up, ut;
		logic [CAL_W-1:0] word;
		longint           ut_wide;
		int               span;
		baro_reading_t    at_reset;

		at_reset = '{pressure: 0, temperature: TEMP_REF};

		// Hold reset, release on a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Zero calibration: every pair reads 0 at 20 degC
		add_item('0, '0, 1'b1, at_reset);
		add_item(RAW_MAX, RAW_MAX, 1'b1, at_reset);
		add_item(RAW_MAX, '0, 1'b1, at_reset);
		add_item('0, RAW_MAX, 1'b1, at_reset);
		// Upper data bits are dropped, so zero words stay zero
		for (int i = 0; i < NUM_REGS; i++)
			add_cfg(i, 32'hA5A5_0000);
		add_item(24'h800000, 24'h123456, 1'b1, at_reset);
		// Writes past the register list are ignored
		add_cfg(NUM_REGS, '1);
		add_cfg(NUM_REGS + 1, '1);
		add_item(RAW_MAX, RAW_MAX, 1'b1, at_reset);
		// Typical calibration: warm, cold and very cold pairs
		for (int i = 0; i < NUM_REGS; i++)
			add_cfg(i, {16'h5A5A, NOMINAL_CAL[i]});
		add_item(24'd9085466, 24'd8569150, 1'b0, at_reset);
		add_item(RAW_MAX, 24'd8000000, 1'b0, at_reset);
		add_item(RAW_MAX, '0, 1'b0, at_reset);
		add_item('0, RAW_MAX, 1'b0, at_reset);
		add_item(RAW_MAX, RAW_MAX, 1'b0, at_reset);
		add_item('0, '0, 1'b0, at_reset);
		add_item(24'd8000000, 24'd7500000, 1'b0, at_reset);
		// Full-scale words: pressure wraps
		for (int i = 0; i < NUM_REGS; i++)
			add_cfg(i, '1);
		add_item(RAW_MAX, RAW_MAX, 1'b0, at_reset);
		add_item(RAW_MAX, '0, 1'b0, at_reset);
		add_item('0, '0, 1'b0, at_reset);
		add_item(24'h123456, 24'hFFFF00, 1'b0, at_reset);

		foreach (stim_rows[k]) begin
			if (stim_rows[k].kind == ROW_CFG) begin
				settle_pipeline();
				apb_access(1'b1, stim_rows[k].reg_index, stim_rows[k].reg_value);
			end else begin
				send_item(stim_rows[k].up, stim_rows[k].ut, stim_rows[k].typed,
					stim_rows[k].reading);
			end
		end
		cal_settings += 4;
		settle_pipeline();
		verify_regs();

		// Random pairs under a new calibration per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			settle_pipeline();
			for (int i = 0; i < NUM_REGS; i++) begin
				case (ph)
					0: word = NOMINAL_CAL[i];
					1: word = CAL_MAX;
					3: word = (i == REG_REF_TEMP) ? '0 :
						(i == REG_TEMP_SLOPE) ? CAL_MAX : CAL_W'($urandom);
					4: begin
						case ($urandom_range(2))
							0:       word = '0;
							1:       word = CAL_MAX;
							default: word = CAL_W'($urandom);
						endcase
					end
					5: word = (i == REG_REF_TEMP) ? CAL_MAX : CAL_W'($urandom);
					default: word = CAL_W'($urandom);
				endcase
				apb_access(1'b1, i, {CAL_W'($urandom), word});
			end
			verify_regs();
			cal_settings++;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				no_idle = (ph == 2 && n >= 30 && n < 200);
				if (ph == 3 && n == 40)
					hold_request = 1'b1;
				if (ph == 4 && n == 100)
					settle_pipeline();

				if ($urandom_range(7) == 0)
					up = $urandom_range(1) ? RAW_MAX : '0;
				else
					up = RAW_W'($urandom);

				// Aim half the temperatures near the reference to hit every region
				case ($urandom_range(3))
					0: ut = RAW_W'($urandom);
					1: ut = $urandom_range(1) ? RAW_MAX : '0;
					default: begin
						span    = $urandom_range(RAW_W - 1);
						ut_wide = longint'(cal_word[REG_REF_TEMP]) * 256
							+ ($urandom_range(1) ? 1 : -1)
							* longint'($urandom_range((1 << span) - 1));
						if (ut_wide < 0)
							ut = '0;
						else if (ut_wide > RAW_MAX)
							ut = RAW_MAX;
						else
							ut = ut_wide[RAW_W-1:0];
					end
				endcase
				send_item(up, ut, 1'b0, at_reset);
			end
			no_idle = 1'b0;
		end

		// Drain and watch for stray result words
		settle_pipeline();
		repeat (2 * LATENCY) @(posedge clk);

		$display("Checked %0d results from %0d raw pairs under %0d calibration settings.",
			results_seen, items_sent, cal_settings);
		$display("Pairs below 20 degC: %0d, below -15 degC: %0d; mismatches: %0d.",
			cold_items, frigid_items, errors);
		if (errors == 0 && expected_readings.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
